// File: hw/rtl/rpr_pkg.sv
// shared constants, types and state codes for the random page replacement block
package rpr_pkg;

    localparam int MAX_PAGES    = 128;
    localparam int PAGE_W       = $clog2(MAX_PAGES);
    localparam int CNT_W        = $clog2(MAX_PAGES + 1);
    localparam int PAGE_FIELD_W = 7;
    localparam int RND_W        = 16;
    localparam int REM_CNT_W    = $clog2(RND_W);
    localparam int CFG_W        = 8;
    localparam int HIT_W        = 16;
    localparam int CMP_W        = 16;

    // scan group geometry: eight present bits looked at per cycle
    localparam int GRP_SIZE = 8;
    localparam int GRP_SH   = 3;
    localparam int NGRP     = (MAX_PAGES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GI_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W    = NGRP * GRP_SIZE;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_COUNT  = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_LIMIT_RST = 8'd128;
    localparam logic [CFG_W-1:0] PAGE_COUNT_RST  = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SCAN,
        ST_EMIT
    } rpr_state_t;

    // request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } rpr_rem_req_t;

    // answer from the remainder unit
    typedef struct packed {
        logic              done;
        logic [PAGE_W-1:0] remainder;
    } rpr_rem_rsp_t;

endpackage

// File: hw/rtl/random_page_replacement.sv
// top level of the random page replacement block: present bits, counters, victim scan
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata: page, random_value; tlast: final_ref
// m_       out  m_tvalid/m_tready   tdata: hit, evicted_valid, evicted_page,
//                                          hit_total, bad_page; tlast: run_done
// cfg_     in   cfg_wr_en           cfg_addr, cfg_wdata (no read-back)
//
// one word at a time: hit, load and bad-page words go from accept through the
// EVAL and EMIT states to the output register; a miss with all frames in use adds
// the DIV state, which waits on the serial remainder (random_value mod page count),
// and the SCAN state, an 8-bit-wide circular scan over the present bits
// aresetn (sync, active low) clears present bits, frame and hit counts
// the result sits in an output register; the next word is taken while it waits
module random_page_replacement
    import rpr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] page, [22:7] random_value, [23] zero
    input  logic                   s_tlast,   // final_ref
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] hit, [1] evicted_valid,
                                              // [8:2] evicted_page, [24:9] hit_total,
                                              // [25] bad_page, [31:26] zero
    output logic                   m_tlast    // run_done
);

    // config registers
    logic [CFG_W-1:0] frame_limit_reg;
    logic [CFG_W-1:0] page_count_reg;

    // block state
    rpr_state_t        state_reg, state_next;
    logic [MAX_PAGES-1:0] present_reg, present_next;
    logic [CFG_W-1:0]  frames_used_reg, frames_used_next;
    logic [HIT_W-1:0]  hit_cnt_reg, hit_cnt_next;

    // current word
    logic [PAGE_FIELD_W-1:0] pg_reg, pg_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic              fin_reg, fin_next;

    // result of the current word before it goes out
    logic              res_hit_reg, res_hit_next;
    logic              res_ev_reg, res_ev_next;
    logic [PAGE_W-1:0] res_ev_pg_reg, res_ev_pg_next;
    logic              res_bad_reg, res_bad_next;

    // scan position
    logic [PAGE_W-1:0] start_reg, start_next;
    logic [GI_W-1:0]   grp_reg, grp_next;
    logic              pass_reg, pass_next;

    // output register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    rpr_rem_req_t rem_req;
    rpr_rem_rsp_t rem_rsp;

    // effective page count, capped at the number of present bits
    logic [CNT_W-1:0]  eff;
    logic              pg_bad;
    logic [PAGE_W-1:0] pg_idx;

    // scan datapath
    logic [PAD_W-1:0]    padded;
    logic [GRP_SIZE-1:0] grp_bits;
    logic [GRP_SIZE-1:0] grp_mask;
    logic [CMP_W-1:0]    pos;
    logic                found;
    logic [GRP_SH-1:0]   found_j;
    logic [GI_W-1:0]     last_grp;
    logic [PAGE_W-1:0]   victim;

    logic out_free;
    logic s_acc;

    rpr_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        if (CMP_W'(page_count_reg) > CMP_W'(MAX_PAGES)) begin
            eff = CNT_W'(MAX_PAGES);
        end else begin
            eff = CNT_W'(page_count_reg);
        end
        pg_bad = !(CMP_W'(pg_reg) < CMP_W'(eff));
        pg_idx = PAGE_W'(pg_reg);
    end

    // one group of eight present bits per cycle, lowest qualifying bit wins
    always_comb begin
        padded = '0;
        padded[MAX_PAGES-1:0] = present_reg;
        grp_bits = padded[grp_reg*GRP_SIZE +: GRP_SIZE];
        pos = '0;
        for (int j = 0; j < GRP_SIZE; j++) begin
            pos = CMP_W'({grp_reg, GRP_SH'(j)});
            if (!pass_reg) begin
                // first pass: from the start point up to the page count
                grp_mask[j] = (pos >= CMP_W'(start_reg)) && (pos < CMP_W'(eff));
            end else begin
                // wrapped pass: from page zero up to the start point
                grp_mask[j] = (pos < CMP_W'(start_reg));
            end
        end
        found   = 1'b0;
        found_j = '0;
        for (int j = GRP_SIZE - 1; j >= 0; j--) begin
            if (grp_bits[j] && grp_mask[j]) begin
                found   = 1'b1;
                found_j = GRP_SH'(j);
            end
        end
        if (!pass_reg) begin
            last_grp = GI_W'((CMP_W'(eff) - 1'b1) >> GRP_SH);
        end else begin
            last_grp = GI_W'(start_reg >> GRP_SH);
        end
        victim = PAGE_W'({grp_reg, found_j});
    end

    always_comb begin
        state_next       = state_reg;
        present_next     = present_reg;
        frames_used_next = frames_used_reg;
        hit_cnt_next     = hit_cnt_reg;
        pg_next          = pg_reg;
        rnd_next         = rnd_reg;
        fin_next         = fin_reg;
        res_hit_next     = res_hit_reg;
        res_ev_next      = res_ev_reg;
        res_ev_pg_next   = res_ev_pg_reg;
        res_bad_next     = res_bad_reg;
        start_next       = start_reg;
        grp_next         = grp_reg;
        pass_next        = pass_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = rnd_reg;
        rem_req.divisor  = eff;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    pg_next    = s_tdata[PAGE_FIELD_W-1:0];
                    rnd_next   = s_tdata[PAGE_FIELD_W +: RND_W];
                    fin_next   = s_tlast;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_hit_next   = 1'b0;
                res_ev_next    = 1'b0;
                res_ev_pg_next = '0;
                res_bad_next   = 1'b0;
                if (pg_bad) begin
                    res_bad_next = 1'b1;
                    state_next   = ST_EMIT;
                end else if (present_reg[pg_idx]) begin
                    res_hit_next = 1'b1;
                    if (hit_cnt_reg != '1) begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end else if (frames_used_reg < frame_limit_reg) begin
                    // free frame: load the page
                    frames_used_next     = frames_used_reg + 1'b1;
                    present_next[pg_idx] = 1'b1;
                    state_next           = ST_EMIT;
                end else begin
                    // all frames in use: find a victim from a random start
                    rem_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_rsp.done) begin
                    start_next = rem_rsp.remainder;
                    grp_next   = GI_W'(rem_rsp.remainder >> GRP_SH);
                    pass_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (found) begin
                    res_ev_next          = 1'b1;
                    res_ev_pg_next       = victim;
                    present_next[victim] = 1'b0;
                    present_next[pg_idx] = 1'b1;
                    state_next           = ST_EMIT;
                end else if (grp_reg == last_grp) begin
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        grp_next  = '0;
                    end else begin
                        // nothing to evict: load without a victim
                        present_next[pg_idx] = 1'b1;
                        state_next           = ST_EMIT;
                    end
                end else begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0]    = res_hit_reg;
                    m_tdata_next[1]    = res_ev_reg;
                    m_tdata_next[8:2]  = PAGE_FIELD_W'(res_ev_pg_reg);
                    m_tdata_next[24:9] = hit_cnt_reg;
                    m_tdata_next[25]   = res_bad_reg;
                    m_tlast_next  = fin_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // config writes, taken at any time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_limit_reg <= FRAME_LIMIT_RST;
            page_count_reg  <= PAGE_COUNT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_FRAME_LIMIT) begin
                frame_limit_reg <= cfg_wdata;
            end else if (cfg_addr == REG_PAGE_COUNT) begin
                page_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            present_reg     <= '0;
            frames_used_reg <= '0;
            hit_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            present_reg     <= present_next;
            frames_used_reg <= frames_used_next;
            hit_cnt_reg     <= hit_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        pg_reg        <= pg_next;
        rnd_reg       <= rnd_next;
        fin_reg       <= fin_next;
        res_hit_reg   <= res_hit_next;
        res_ev_reg    <= res_ev_next;
        res_ev_pg_reg <= res_ev_pg_next;
        res_bad_reg   <= res_bad_next;
        start_reg     <= start_next;
        grp_reg       <= grp_next;
        pass_reg      <= pass_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

endmodule

// File: hw/rtl/rpr_rem.sv
// bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle
module rpr_rem
    import rpr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rpr_rem_req_t req,
    output rpr_rem_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[RND_W-1]};
        diff      = shifted - {1'b0, div_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = REM_CNT_W'(RND_W - 1);
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // restoring step: shift in next bit, subtract when it fits
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = diff[CNT_W-1:0];
            end else begin
                rem_next = shifted[CNT_W-1:0];
            end
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = PAGE_W'(rem_reg);

endmodule
